### hdl/rbp_pkg.sv
// Shared constants, types and saturating fixed-point functions of the Boris pusher.
`timescale 1ns / 1ps

package rbp_pkg;

    localparam int W = 32;
    localparam int F = 16;

    localparam int IN_BITS  = ((10 * W) + 7) / 8 * 8;
    localparam int OUT_RAW  = 6 * W - 1;
    localparam int OUT_BITS = (OUT_RAW + 7) / 8 * 8;
    localparam int OUT_PAD  = OUT_BITS - OUT_RAW;

    localparam int DW       = W + F;
    localparam int DIV_LAT  = DW + 2;
    localparam int RDW      = W - 1 + F;
    localparam int RW2      = (RDW + 1) / 2 * 2;
    localparam int NR       = RW2 / 2;
    localparam int RMW      = NR + 3;
    localparam int SQRT_LAT = NR + 2;
    localparam int NST      = 15;

    typedef logic signed [W-1:0] word_t;
    typedef logic [1:0] cfg_idx_t;

    localparam cfg_idx_t REG_QM     = 2'd0;
    localparam cfg_idx_t REG_HALFDT = 2'd1;
    localparam cfg_idx_t REG_DT     = 2'd2;

    localparam word_t        W_MAX = {1'b0, {(W-1){1'b1}}};
    localparam word_t        W_MIN = {1'b1, {(W-1){1'b0}}};
    localparam word_t        ONE   = (F < W - 1) ? word_t'(64'd1 << F) : W_MAX;
    localparam word_t        QM_RESET     = word_t'(-64'sd65536);
    localparam logic [W-2:0] HALFDT_RESET = (W-1)'(3277);
    localparam logic [W-2:0] DT_RESET     = (W-1)'(6554);

    typedef struct packed {
        logic  vld;
        word_t k;
        word_t x0;
        word_t sc;
        word_t [2:0] v1;
        word_t [2:0] v2;
        word_t [2:0] v3;
        word_t [5:0] v4;
        word_t [8:0] mat;
    } ctx_t;

    function automatic logic [W-1:0] fx_mag(word_t a);
        fx_mag = a[W-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic word_t fx_from_mag(logic neg, logic [2*W-1:0] m);
        logic [2*W-1:0] lim;
        lim = (2*W)'(W_MAX);
        if (neg)
        begin
            if (m > lim + 1'b1)
                fx_from_mag = W_MIN;
            else
                fx_from_mag = word_t'(~m[W-1:0] + 1'b1);
        end
        else
        begin
            if (m > lim)
                fx_from_mag = W_MAX;
            else
                fx_from_mag = word_t'(m[W-1:0]);
        end
    endfunction

    function automatic word_t fx_add(word_t a, word_t b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
            fx_add = s[W] ? W_MIN : W_MAX;
        else
            fx_add = s[W-1:0];
    endfunction

    function automatic word_t fx_sub(word_t a, word_t b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1])
            fx_sub = s[W] ? W_MIN : W_MAX;
        else
            fx_sub = s[W-1:0];
    endfunction

    function automatic word_t fx_dbl(word_t a);
        fx_dbl = fx_add(a, a);
    endfunction

    function automatic word_t fx_mul(word_t a, word_t b);
        logic [2*W-1:0] p;
        p = (2*W)'(fx_mag(a)) * (2*W)'(fx_mag(b));
        fx_mul = fx_from_mag(a[W-1] ^ b[W-1], p >> F);
    endfunction

endpackage

### hdl/rbp_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturated signed result.
`timescale 1ns / 1ps

module rbp_div
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  rbp_pkg::word_t num,
    input  rbp_pkg::word_t den,
    output rbp_pkg::word_t quo
);

    logic [rbp_pkg::W:0]    rem_reg [rbp_pkg::DW+1];
    logic [rbp_pkg::DW-1:0] dvd_reg [rbp_pkg::DW+1];
    logic [rbp_pkg::DW-1:0] quo_reg [rbp_pkg::DW+1];
    logic [rbp_pkg::W-1:0]  den_reg [rbp_pkg::DW+1];
    logic                   neg_reg [rbp_pkg::DW+1];

    logic [rbp_pkg::W:0]    rem_next [rbp_pkg::DW+1];
    logic [rbp_pkg::DW-1:0] quo_next [rbp_pkg::DW+1];
    rbp_pkg::word_t         out_reg;

    always_comb
    begin
        logic [rbp_pkg::W:0] r2;
        for (int i = 0; i <= rbp_pkg::DW; i++)
        begin
            rem_next[i] = '0;
            quo_next[i] = '0;
        end
        for (int i = 1; i <= rbp_pkg::DW; i++)
        begin
            r2 = {rem_reg[i-1][rbp_pkg::W-1:0], dvd_reg[i-1][rbp_pkg::DW-1]};
            if (r2 >= {1'b0, den_reg[i-1]})
            begin
                rem_next[i] = r2 - {1'b0, den_reg[i-1]};
                quo_next[i] = {quo_reg[i-1][rbp_pkg::DW-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = r2;
                quo_next[i] = {quo_reg[i-1][rbp_pkg::DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= rbp_pkg::DW; i++)
            begin
                rem_reg[i] <= '0;
                dvd_reg[i] <= '0;
                quo_reg[i] <= '0;
                den_reg[i] <= '0;
                neg_reg[i] <= 1'b0;
            end
            out_reg <= '0;
        end
        else if (en)
        begin
            rem_reg[0] <= '0;
            dvd_reg[0] <= rbp_pkg::DW'(rbp_pkg::fx_mag(num)) << rbp_pkg::F;
            quo_reg[0] <= '0;
            den_reg[0] <= rbp_pkg::fx_mag(den);
            neg_reg[0] <= num[rbp_pkg::W-1] ^ den[rbp_pkg::W-1];
            for (int i = 1; i <= rbp_pkg::DW; i++)
            begin
                rem_reg[i] <= rem_next[i];
                dvd_reg[i] <= dvd_reg[i-1] << 1;
                quo_reg[i] <= quo_next[i];
                den_reg[i] <= den_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
            out_reg <= rbp_pkg::fx_from_mag(neg_reg[rbp_pkg::DW],
                                            (2*rbp_pkg::W)'(quo_reg[rbp_pkg::DW]));
        end
    end

    assign quo = out_reg;

endmodule

### hdl/rbp_sqrt.sv
// Pipelined digit-by-digit square root of a fixed-point word, one root bit per stage.
`timescale 1ns / 1ps

module rbp_sqrt
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  rbp_pkg::word_t rad,
    output rbp_pkg::word_t root
);

    logic [rbp_pkg::RMW-1:0] rem_reg  [rbp_pkg::NR+1];
    logic [rbp_pkg::RW2-1:0] rad_reg  [rbp_pkg::NR+1];
    logic [rbp_pkg::NR-1:0]  root_reg [rbp_pkg::NR+1];

    logic [rbp_pkg::RMW-1:0] rem_next  [rbp_pkg::NR+1];
    logic [rbp_pkg::NR-1:0]  root_next [rbp_pkg::NR+1];
    logic [rbp_pkg::W-2:0]   pos;
    rbp_pkg::word_t          out_reg;

    assign pos = rad[rbp_pkg::W-1] ? '0 : rad[rbp_pkg::W-2:0];

    always_comb
    begin
        logic [rbp_pkg::RMW-1:0] r2;
        logic [rbp_pkg::RMW-1:0] trial;
        for (int i = 0; i <= rbp_pkg::NR; i++)
        begin
            rem_next[i]  = '0;
            root_next[i] = '0;
        end
        for (int i = 1; i <= rbp_pkg::NR; i++)
        begin
            r2    = {rem_reg[i-1][rbp_pkg::RMW-3:0], rad_reg[i-1][rbp_pkg::RW2-1 -: 2]};
            trial = {1'b0, root_reg[i-1], 2'b01};
            if (r2 >= trial)
            begin
                rem_next[i]  = r2 - trial;
                root_next[i] = {root_reg[i-1][rbp_pkg::NR-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = r2;
                root_next[i] = {root_reg[i-1][rbp_pkg::NR-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= rbp_pkg::NR; i++)
            begin
                rem_reg[i]  <= '0;
                rad_reg[i]  <= '0;
                root_reg[i] <= '0;
            end
            out_reg <= '0;
        end
        else if (en)
        begin
            rem_reg[0]  <= '0;
            rad_reg[0]  <= rbp_pkg::RW2'(pos) << rbp_pkg::F;
            root_reg[0] <= '0;
            for (int i = 1; i <= rbp_pkg::NR; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                rad_reg[i]  <= rad_reg[i-1] << 2;
                root_reg[i] <= root_next[i];
            end
            out_reg <= rbp_pkg::fx_from_mag(1'b0, (2*rbp_pkg::W)'(root_reg[rbp_pkg::NR]));
        end
    end

    assign root = out_reg;

endmodule

### hdl/relativistic_boris_pusher.sv
// Top level of the relativistic Boris particle pusher pipeline.
`timescale 1ns / 1ps

// One particle enters per clock and one result leaves per clock unless the output stalls.
// The pipeline holds two square-root pipelines (one root bit per stage) and three divider
// pipelines (one quotient bit per stage), working on Q16.16 words.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Configuration must be written while the pipeline holds no item.

module relativistic_boris_pusher
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // field_ex, field_ey, field_ez, field_bx, field_by, field_bz,
    // mom_x_in, mom_y_in, mom_z_in, pos_x_in
    input  logic [rbp_pkg::IN_BITS-1:0]    s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // mom_x_out, mom_y_out, mom_z_out, pos_x_out, pos_x_old, lorentz_factor, zero pad
    output logic [rbp_pkg::OUT_BITS-1:0]   m_axis_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  rbp_pkg::cfg_idx_t              cfg_index,
    input  logic [rbp_pkg::W-1:0]          cfg_data
);

    localparam int W = rbp_pkg::W;

    rbp_pkg::word_t  qm_reg;
    logic [W-2:0]    hdt_reg;
    logic [W-2:0]    dt_reg;

    rbp_pkg::ctx_t   st_reg  [rbp_pkg::NST];
    rbp_pkg::ctx_t   st_next [rbp_pkg::NST];
    rbp_pkg::ctx_t   da_reg  [rbp_pkg::SQRT_LAT];
    rbp_pkg::ctx_t   db_reg  [rbp_pkg::DIV_LAT];
    rbp_pkg::ctx_t   dc_reg  [rbp_pkg::DIV_LAT];
    rbp_pkg::ctx_t   dd_reg  [rbp_pkg::SQRT_LAT];
    rbp_pkg::ctx_t   de_reg  [rbp_pkg::DIV_LAT];
    rbp_pkg::ctx_t   db_in;
    rbp_pkg::ctx_t   de_in;

    rbp_pkg::word_t  g1;
    rbp_pkg::word_t  g2;
    rbp_pkg::word_t  alpha;
    rbp_pkg::word_t  inv;
    rbp_pkg::word_t  dx;
    logic            en;

    assign en            = !st_reg[rbp_pkg::NST-1].vld || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qm_reg  <= rbp_pkg::QM_RESET;
            hdt_reg <= rbp_pkg::HALFDT_RESET;
            dt_reg  <= rbp_pkg::DT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rbp_pkg::REG_QM:     qm_reg  <= cfg_data;
                rbp_pkg::REG_HALFDT: hdt_reg <= cfg_data[W-2:0];
                rbp_pkg::REG_DT:     dt_reg  <= cfg_data[W-2:0];
                default:             ;
            endcase
        end
    end

    rbp_sqrt u_sqrt1 (.clk(clk), .rst_n(rst_n), .en(en),
                      .rad(st_reg[4].sc), .root(g1));

    rbp_div u_div1 (.clk(clk), .rst_n(rst_n), .en(en),
                    .num(da_reg[rbp_pkg::SQRT_LAT-1].k), .den(g1), .quo(alpha));

    rbp_div u_div2 (.clk(clk), .rst_n(rst_n), .en(en),
                    .num(rbp_pkg::ONE), .den(st_reg[7].sc), .quo(inv));

    rbp_sqrt u_sqrt2 (.clk(clk), .rst_n(rst_n), .en(en),
                      .rad(st_reg[13].sc), .root(g2));

    rbp_div u_div3 (.clk(clk), .rst_n(rst_n), .en(en),
                    .num(dd_reg[rbp_pkg::SQRT_LAT-1].v4[3]), .den(g2), .quo(dx));

    always_comb
    begin
        rbp_pkg::word_t one;
        rbp_pkg::word_t tx;
        rbp_pkg::word_t ty;
        rbp_pkg::word_t tz;
        rbp_pkg::word_t tx2;
        rbp_pkg::word_t ty2;
        rbp_pkg::word_t tz2;
        rbp_pkg::word_t txty;
        rbp_pkg::word_t tytz;
        rbp_pkg::word_t tztx;

        one = rbp_pkg::ONE;

        st_next[0]     = '0;
        st_next[0].vld = s_axis_tvalid;
        for (int j = 0; j < 3; j++)
        begin
            st_next[0].v1[j] = s_axis_tdata[j*W +: W];
            st_next[0].v2[j] = s_axis_tdata[(j+3)*W +: W];
            st_next[0].v3[j] = s_axis_tdata[(j+6)*W +: W];
        end
        st_next[0].x0 = s_axis_tdata[9*W +: W];
        st_next[0].k  = rbp_pkg::fx_mul(qm_reg, {1'b0, hdt_reg});

        st_next[1] = st_reg[0];
        for (int j = 0; j < 3; j++)
            st_next[1].v1[j] = rbp_pkg::fx_mul(st_reg[0].v1[j], st_reg[0].k);

        st_next[2] = st_reg[1];
        for (int j = 0; j < 3; j++)
            st_next[2].v3[j] = rbp_pkg::fx_add(st_reg[1].v3[j], st_reg[1].v1[j]);

        st_next[3] = st_reg[2];
        for (int j = 0; j < 3; j++)
            st_next[3].v4[j] = rbp_pkg::fx_mul(st_reg[2].v3[j], st_reg[2].v3[j]);

        st_next[4]    = st_reg[3];
        st_next[4].sc = rbp_pkg::fx_add(rbp_pkg::fx_add(rbp_pkg::fx_add(one,
                            st_reg[3].v4[0]), st_reg[3].v4[1]), st_reg[3].v4[2]);

        db_in    = da_reg[rbp_pkg::SQRT_LAT-1];
        db_in.sc = g1;

        st_next[5] = db_reg[rbp_pkg::DIV_LAT-1];
        for (int j = 0; j < 3; j++)
            st_next[5].v2[j] = rbp_pkg::fx_mul(alpha, db_reg[rbp_pkg::DIV_LAT-1].v2[j]);

        tx = st_reg[5].v2[0];
        ty = st_reg[5].v2[1];
        tz = st_reg[5].v2[2];
        st_next[6] = st_reg[5];
        st_next[6].v4[0] = rbp_pkg::fx_mul(tx, tx);
        st_next[6].v4[1] = rbp_pkg::fx_mul(ty, ty);
        st_next[6].v4[2] = rbp_pkg::fx_mul(tz, tz);
        st_next[6].v4[3] = rbp_pkg::fx_mul(tx, ty);
        st_next[6].v4[4] = rbp_pkg::fx_mul(ty, tz);
        st_next[6].v4[5] = rbp_pkg::fx_mul(tz, tx);

        tx   = st_reg[6].v2[0];
        ty   = st_reg[6].v2[1];
        tz   = st_reg[6].v2[2];
        tx2  = st_reg[6].v4[0];
        ty2  = st_reg[6].v4[1];
        tz2  = st_reg[6].v4[2];
        txty = st_reg[6].v4[3];
        tytz = st_reg[6].v4[4];
        tztx = st_reg[6].v4[5];
        st_next[7]    = st_reg[6];
        st_next[7].sc = rbp_pkg::fx_add(rbp_pkg::fx_add(rbp_pkg::fx_add(one, tx2), ty2), tz2);
        st_next[7].mat[0] = rbp_pkg::fx_sub(rbp_pkg::fx_sub(rbp_pkg::fx_add(one, tx2), ty2),
                                            tz2);
        st_next[7].mat[1] = rbp_pkg::fx_dbl(rbp_pkg::fx_add(txty, tz));
        st_next[7].mat[2] = rbp_pkg::fx_dbl(rbp_pkg::fx_sub(tztx, ty));
        st_next[7].mat[3] = rbp_pkg::fx_dbl(rbp_pkg::fx_sub(txty, tz));
        st_next[7].mat[4] = rbp_pkg::fx_sub(rbp_pkg::fx_add(rbp_pkg::fx_sub(one, tx2), ty2),
                                            tz2);
        st_next[7].mat[5] = rbp_pkg::fx_dbl(rbp_pkg::fx_add(tytz, tx));
        st_next[7].mat[6] = rbp_pkg::fx_dbl(rbp_pkg::fx_add(tztx, ty));
        st_next[7].mat[7] = rbp_pkg::fx_dbl(rbp_pkg::fx_sub(tytz, tx));
        st_next[7].mat[8] = rbp_pkg::fx_add(rbp_pkg::fx_sub(rbp_pkg::fx_sub(one, tx2), ty2),
                                            tz2);

        st_next[8]    = dc_reg[rbp_pkg::DIV_LAT-1];
        st_next[8].sc = inv;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                st_next[8].mat[r*3+c] = rbp_pkg::fx_mul(dc_reg[rbp_pkg::DIV_LAT-1].mat[r*3+c],
                                                        dc_reg[rbp_pkg::DIV_LAT-1].v3[c]);

        st_next[9] = st_reg[8];
        for (int r = 0; r < 3; r++)
            st_next[9].v3[r] = rbp_pkg::fx_add(rbp_pkg::fx_add(st_reg[8].mat[r*3],
                                   st_reg[8].mat[r*3+1]), st_reg[8].mat[r*3+2]);

        st_next[10] = st_reg[9];
        for (int r = 0; r < 3; r++)
            st_next[10].v3[r] = rbp_pkg::fx_mul(st_reg[9].v3[r], st_reg[9].sc);

        st_next[11] = st_reg[10];
        for (int r = 0; r < 3; r++)
            st_next[11].v3[r] = rbp_pkg::fx_add(st_reg[10].v3[r], st_reg[10].v1[r]);

        st_next[12] = st_reg[11];
        for (int j = 0; j < 3; j++)
            st_next[12].v4[j] = rbp_pkg::fx_mul(st_reg[11].v3[j], st_reg[11].v3[j]);
        st_next[12].v4[3] = rbp_pkg::fx_mul({1'b0, dt_reg}, st_reg[11].v3[0]);

        st_next[13]    = st_reg[12];
        st_next[13].sc = rbp_pkg::fx_add(rbp_pkg::fx_add(rbp_pkg::fx_add(one,
                             st_reg[12].v4[0]), st_reg[12].v4[1]), st_reg[12].v4[2]);

        de_in    = dd_reg[rbp_pkg::SQRT_LAT-1];
        de_in.sc = g2;

        st_next[14]       = de_reg[rbp_pkg::DIV_LAT-1];
        st_next[14].v4[4] = rbp_pkg::fx_add(de_reg[rbp_pkg::DIV_LAT-1].x0, dx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rbp_pkg::NST; i++)
                st_reg[i] <= '0;
            for (int i = 0; i < rbp_pkg::SQRT_LAT; i++)
            begin
                da_reg[i] <= '0;
                dd_reg[i] <= '0;
            end
            for (int i = 0; i < rbp_pkg::DIV_LAT; i++)
            begin
                db_reg[i] <= '0;
                dc_reg[i] <= '0;
                de_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < rbp_pkg::NST; i++)
                st_reg[i] <= st_next[i];
            da_reg[0] <= st_reg[4];
            dd_reg[0] <= st_reg[13];
            db_reg[0] <= db_in;
            dc_reg[0] <= st_reg[7];
            de_reg[0] <= de_in;
            for (int i = 1; i < rbp_pkg::SQRT_LAT; i++)
            begin
                da_reg[i] <= da_reg[i-1];
                dd_reg[i] <= dd_reg[i-1];
            end
            for (int i = 1; i < rbp_pkg::DIV_LAT; i++)
            begin
                db_reg[i] <= db_reg[i-1];
                dc_reg[i] <= dc_reg[i-1];
                de_reg[i] <= de_reg[i-1];
            end
        end
    end

    assign m_axis_tvalid = st_reg[rbp_pkg::NST-1].vld;
    assign m_axis_tdata  = {{rbp_pkg::OUT_PAD{1'b0}},
                            st_reg[rbp_pkg::NST-1].sc[W-2:0],
                            st_reg[rbp_pkg::NST-1].x0,
                            st_reg[rbp_pkg::NST-1].v4[4],
                            st_reg[rbp_pkg::NST-1].v3[2],
                            st_reg[rbp_pkg::NST-1].v3[1],
                            st_reg[rbp_pkg::NST-1].v3[0]};

endmodule
